// ===== src/ssfi_pkg.sv =====
// package for the sticky-sampling frequent-item counter
`default_nettype none
package ssfi_pkg;
	localparam int TableSets = 256;
	localparam int TableWays = 4;
	localparam int CountBits = 16;
	localparam int MaxReport = 64;
	localparam int IdBits = 32;
	localparam logic [31:0] LfsrTaps = 32'h8020_0003;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DECAY  = 2'd1,
		REQ_REPORT = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_ADMIT = 2'd0,
		CFG_MINCNT = 2'd1,
		CFG_SEED = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_DEC_RD,
		ST_DEC_WAIT,
		ST_DEC_RUN,
		ST_REP_RD,
		ST_REP_WAIT,
		ST_REP_CHK,
		ST_REP_LAST,
		ST_CLR
	} state_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] v);
		logic [31:0] r;
		r = v >> 1;
		if (v[0]) r = r ^ LfsrTaps;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/ssfi_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module ssfi_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== src/sticky_sampling_frequent_items.sv =====
// top level: sticky-sampling frequent-item counter over a set-associative table
// insert: a read and a check per way of the item's set, until a hit or the last way
// decay: per slot a read, a wait, then coin draws until a 0 is drawn or the count is zero
// report: per slot a read, a wait and a check, held by output stalls; clear zeroes every slot
// results leave through a one-deep output register; after reset a clearing pass over all slots
// zeroes the counts; no item is taken before it ends, configuration writes are taken throughout
`default_nettype none
module sticky_sampling_frequent_items
	import ssfi_pkg::*;
#(
	parameter int COUNT_BITS = CountBits,
	parameter int MAX_REPORT = MaxReport
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // item_id[31:0]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // item_id_out[31:0]
	output logic             m_tuser,   // found
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int Slots = TableSets * TableWays;
	localparam int SlotBits = $clog2(Slots);
	localparam int SetBits = $clog2(TableSets);
	localparam int WayBits = $clog2(TableWays);
	localparam int RepBits = $clog2(MAX_REPORT + 1);
	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	state_t state_q, state_d;
	logic [16:0] admit_q;
	logic [15:0] min_q;
	logic [31:0] lfsr_q, lfsr_d;
	logic [SlotBits-1:0] slot_q;
	logic [SlotBits:0] walk_q;
	logic [WayBits-1:0] way_q;
	logic [31:0] id_q;
	logic hit_q, free_q;
	logic [WayBits-1:0] free_way_q;
	logic [RepBits-1:0] nrep_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic ram_we, key_we;
	logic [SlotBits-1:0] ram_addr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
	logic [31:0] key_rdata;

	logic ob_full_q, ob_found_q, ob_last_q;
	logic [31:0] ob_id_q;
	logic pend_q;
	logic [31:0] pend_id_q;
	logic push, push_found, push_last;
	logic [31:0] push_id;

	ssfi_ram #(.Width(COUNT_BITS), .Depth(Slots)) u_cnt (
		.clk, .we(ram_we), .addr(ram_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
	);
	ssfi_ram #(.Width(32), .Depth(Slots)) u_key (
		.clk, .we(key_we), .addr(ram_addr), .wdata(id_q), .rdata(key_rdata)
	);

	wire logic accept = s_tvalid && s_tready;
	wire logic [1:0] req = s_tuser;
	wire logic [31:0] in_id = s_tdata;
	wire logic [SetBits-1:0] in_set = in_id[SetBits-1:0];
	wire logic [31:0] draw_lfsr = lfsr_next(lfsr_q);
	wire logic cur_live = (cnt_rdata != '0);
	wire logic last_way = (way_q == WayBits'(TableWays - 1));
	wire logic slot_end = (walk_q == (SlotBits+1)'(Slots - 1));
	wire logic ob_free = !ob_full_q || m_tready;

	// report holds one pending item so that the last flag can be set on the final one
	wire logic rep_qual = cur_live && ({16'd0, cnt_rdata} > {{(COUNT_BITS){1'b0}}, min_q});
	wire logic rep_cap = (nrep_q == RepBits'(MAX_REPORT - 1));
	wire logic rep_stop = rep_qual && pend_q && rep_cap;

	assign s_tready = (state_q == ST_IDLE) && !ob_full_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: if (slot_end) state_d = ST_IDLE;
			ST_IDLE: if (accept) begin
				unique case (req_t'(req))
					REQ_INSERT: state_d = ST_INS_RD;
					REQ_DECAY:  state_d = ST_DEC_RD;
					REQ_REPORT: state_d = ST_REP_RD;
					REQ_CLEAR:  state_d = ST_CLR;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_INS_RD:  state_d = ST_INS_CHK;
			ST_INS_CHK: if (hit_q || (cur_live && key_rdata == id_q) || last_way)
				state_d = ST_IDLE;
				else state_d = ST_INS_RD;
			ST_DEC_RD:   state_d = ST_DEC_WAIT;
			ST_DEC_WAIT: state_d = ST_DEC_RUN;
			ST_DEC_RUN: if (cnt_q == '0 || !draw_lfsr[0]) state_d = slot_end ? ST_IDLE : ST_DEC_RD;
			ST_REP_RD:   state_d = ST_REP_WAIT;
			ST_REP_WAIT: state_d = ST_REP_CHK;
			ST_REP_CHK: if (ob_free) begin
				if (rep_stop) state_d = ST_IDLE;
				else if (slot_end) state_d = ST_REP_LAST;
				else state_d = ST_REP_RD;
			end
			ST_REP_LAST: if (ob_free) state_d = ST_IDLE;
			ST_CLR: if (slot_end) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ram_we = 1'b0;
		key_we = 1'b0;
		ram_addr = slot_q;
		cnt_wdata = '0;
		lfsr_d = lfsr_q;
		push = 1'b0;
		push_found = 1'b1;
		push_last = 1'b0;
		push_id = pend_id_q;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				ram_we = 1'b1;
				ram_addr = walk_q[SlotBits-1:0];
			end
			ST_INS_CHK: begin
				if (cur_live && key_rdata == id_q) begin
					ram_we = cnt_rdata != CountMax;
					cnt_wdata = cnt_rdata + 1'b1;
				end else if (last_way && !hit_q) begin
					lfsr_d = draw_lfsr;
					if ({1'b0, draw_lfsr[15:0]} < admit_q) begin
						if (free_q) begin
							ram_we = 1'b1;
							key_we = 1'b1;
							ram_addr = {slot_q[SlotBits-1:WayBits], free_way_q};
							cnt_wdata = COUNT_BITS'(1);
						end else if (!cur_live) begin
							ram_we = 1'b1;
							key_we = 1'b1;
							cnt_wdata = COUNT_BITS'(1);
						end
					end
				end
			end
			ST_DEC_RUN: if (cnt_q != '0) begin
				lfsr_d = draw_lfsr;
				if (!draw_lfsr[0]) begin
					ram_we = 1'b1;
					cnt_wdata = cnt_q;
				end else if (cnt_q == COUNT_BITS'(1)) begin
					ram_we = 1'b1;
					cnt_wdata = '0;
				end
			end
			ST_REP_CHK: if (ob_free && rep_qual && pend_q) begin
				push = 1'b1;
				push_last = rep_cap;
			end
			ST_REP_LAST: if (ob_free) begin
				push = 1'b1;
				push_found = pend_q;
				push_last = 1'b1;
				push_id = pend_q ? pend_id_q : '0;
			end
			default: ;
		endcase
		if (cfg_we && cfg_index == CFG_SEED) lfsr_d = (cfg_data != '0) ? cfg_data : 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			admit_q <= 17'd6554;
			min_q <= '0;
			lfsr_q <= 32'd1;
			walk_q <= '0;
			ob_full_q <= 1'b0;
			pend_q <= 1'b0;
			nrep_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lfsr_q <= lfsr_d;
			if (cfg_we && cfg_index == CFG_ADMIT) admit_q <= cfg_data[16:0];
			if (cfg_we && cfg_index == CFG_MINCNT) min_q <= cfg_data[15:0];
			ob_full_q <= push || (ob_full_q && !m_tready);
			unique case (state_q)
				ST_INIT, ST_CLR: walk_q <= slot_end ? '0 : walk_q + 1'b1;
				ST_IDLE: begin
					walk_q <= '0;
					pend_q <= 1'b0;
					nrep_q <= '0;
					hit_q <= 1'b0;
					free_q <= 1'b0;
				end
				ST_INS_CHK: begin
					if (cur_live && key_rdata == id_q) hit_q <= 1'b1;
					if (!cur_live && !free_q) free_q <= 1'b1;
				end
				ST_DEC_RUN: if (cnt_q == '0 || !draw_lfsr[0]) walk_q <= walk_q + 1'b1;
				ST_REP_CHK: if (ob_free) begin
					walk_q <= walk_q + 1'b1;
					if (push) nrep_q <= nrep_q + 1'b1;
					if (rep_qual) pend_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			id_q <= in_id;
			way_q <= '0;
			if (accept && req != REQ_INSERT) slot_q <= '0;
			else slot_q <= {in_set, {WayBits{1'b0}}};
		end
		if (state_q == ST_INS_CHK && !cur_live && !free_q) free_way_q <= way_q;
		if (state_q == ST_INS_CHK) begin
			way_q <= way_q + 1'b1;
			if (!last_way) slot_q <= slot_q + 1'b1;
		end
		if (state_q == ST_DEC_WAIT) cnt_q <= cnt_rdata;
		if (state_q == ST_DEC_RUN) begin
			if (cnt_q != '0 && draw_lfsr[0]) cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0 || !draw_lfsr[0]) slot_q <= slot_q + 1'b1;
		end
		if (state_q == ST_REP_CHK && ob_free) begin
			slot_q <= slot_q + 1'b1;
			if (rep_qual) pend_id_q <= key_rdata;
		end
		if (push) begin
			ob_id_q <= push_id;
			ob_found_q <= push_found;
			ob_last_q <= push_last;
		end
	end

	assign m_tvalid = ob_full_q;
	assign m_tdata = ob_id_q;
	assign m_tuser = ob_found_q;
	assign m_tlast = ob_last_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_rep_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nrep_q <= RepBits'(MAX_REPORT))
		else $error("report count over cap");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ob_free)
		else $error("push into full output");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the sticky-sampling frequent-item counter: scoreboard with table predictor
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import ssfi_pkg::*;

	localparam logic [1:0] CfgNone = 2'd3;
	localparam int SlotTotal = TableSets * TableWays;
	localparam int StallLimit = 40000;

	typedef struct packed {
		logic [31:0] id;
		logic        found;
		logic        last;
	} freq_result_t;

	class freq_scoreboard;
		logic [31:0]  keys [SlotTotal];
		logic [15:0]  counts [SlotTotal];
		logic [31:0]  lfsr;
		logic [16:0]  threshold;
		logic [15:0]  min_count;
		freq_result_t pending_results [$];
		int           errors;

		function void clear_all();
			foreach (counts[i]) begin
				counts[i] = '0;
				keys[i] = '0;
			end
			lfsr = 32'd1;
			threshold = 17'd6554;
			min_count = '0;
			errors = 0;
		endfunction

		function logic [31:0] step_lfsr();
			logic low;
			low = lfsr[0];
			lfsr = lfsr >> 1;
			if (low) lfsr = lfsr ^ 32'h8020_0003;
			return lfsr;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				CFG_ADMIT: threshold = value[16:0];
				CFG_MINCNT: min_count = value[15:0];
				CFG_SEED: lfsr = (value != 0) ? value : 32'd1;
				default: ;
			endcase
		endfunction

		function void note_item(req_t req, logic [31:0] id);
			int base;
			int found_slot;
			logic [31:0] draw;
			int n;
			freq_result_t r;
			base = int'(id % TableSets) * TableWays;
			case (req)
				REQ_INSERT: begin
					found_slot = -1;
					for (int w = 0; w < TableWays; w++)
						if (found_slot < 0 && counts[base + w] != 0 && keys[base + w] == id)
							found_slot = base + w;
					if (found_slot >= 0) begin
						if (counts[found_slot] != 16'hFFFF) counts[found_slot]++;
					end else begin
						draw = step_lfsr() & 32'hFFFF;
						if (draw < {15'd0, threshold}) begin
							for (int w = 0; w < TableWays; w++)
								if (found_slot < 0 && counts[base + w] == 0) begin
									found_slot = base + w;
									keys[found_slot] = id;
									counts[found_slot] = 16'd1;
								end
						end
					end
				end
				REQ_DECAY: begin
					for (int s = 0; s < SlotTotal; s++)
						while (counts[s] != 0) begin
							draw = step_lfsr();
							if (!draw[0]) break;
							counts[s]--;
						end
				end
				REQ_REPORT: begin
					n = 0;
					for (int s = 0; s < SlotTotal && n < MaxReport; s++)
						if (counts[s] != 0 && counts[s] > min_count) begin
							r.id = keys[s];
							r.found = 1'b1;
							r.last = 1'b0;
							pending_results.push_back(r);
							n++;
						end
					if (n == 0) begin
						r.id = '0;
						r.found = 1'b0;
						r.last = 1'b1;
						pending_results.push_back(r);
					end else begin
						r = pending_results.pop_back();
						r.last = 1'b1;
						pending_results.push_back(r);
					end
				end
				default: foreach (counts[i]) counts[i] = '0;
			endcase
		endfunction

		task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h expected %h", what, got, want);
			errors++;
		endtask

		task check_result(logic [31:0] id, logic found, logic last);
			freq_result_t e;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected item id", id, 32'd0);
				return;
			end
			e = pending_results.pop_front();
			if (id !== e.id) flag_mismatch("item id", id, e.id);
			if (found !== e.found) flag_mismatch("found", {31'd0, found}, {31'd0, e.found});
			if (last !== e.last) flag_mismatch("last", {31'd0, last}, {31'd0, e.last});
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        calm = 1'b0;
	int          stall_cycles = 0;
	freq_scoreboard sb;
	logic [31:0] pool [24];

	sticky_sampling_frequent_items dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
		m_tready <= calm || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > StallLimit) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_item(req_t req, logic [31:0] id);
		if (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= id;
		s_tuser <= req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(req, id);
	endtask

	// a report walks the table up to its end or the report cap, so its last item marks the block idle
	task automatic settle();
		send_item(REQ_REPORT, '0);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_items(int count, int id_span);
		int pick;
		logic [31:0] id;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			id = ($urandom_range(9) < 7) ? pool[$urandom_range(id_span - 1)] : $urandom;
			if (pick < 72) send_item(REQ_INSERT, id);
			else if (pick < 80) send_item(REQ_DECAY, $urandom);
			else if (pick < 95) send_item(REQ_REPORT, $urandom);
			else send_item(REQ_CLEAR, $urandom);
		end
	endtask

	initial begin
		sb = new();
		sb.clear_all();
		foreach (pool[i]) pool[i] = (i < 8) ? (i * 256 + 5) : $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_ADMIT, 32'd65536);
		write_reg(CFG_MINCNT, 32'd0);
		write_reg(CFG_SEED, 32'd0);
		write_reg(CfgNone, 32'hFFFF_FFFF);
		end_writes();
		send_item(REQ_INSERT, 32'd0);
		send_item(REQ_INSERT, 32'hFFFF_FFFF);
		send_item(REQ_INSERT, 32'd256);
		send_item(REQ_INSERT, 32'd512);
		send_item(REQ_INSERT, 32'd768);
		send_item(REQ_INSERT, 32'd1024);
		send_item(REQ_INSERT, 32'd0);
		send_item(REQ_INSERT, 32'hAAAA_AAAA);
		send_item(REQ_INSERT, 32'h5555_5555);
		send_item(REQ_REPORT, 32'hFFFF_FFFF);
		send_item(REQ_DECAY, 32'd0);
		send_item(REQ_REPORT, 32'd0);
		send_item(REQ_CLEAR, 32'd0);
		send_item(REQ_REPORT, 32'd0);
		for (int i = 0; i < 20; i++) send_item(REQ_INSERT, i * 3 + 7);
		settle();

		// no admission, then the highest report floor
		write_reg(CFG_ADMIT, 32'd0);
		write_reg(CFG_MINCNT, 32'd65535);
		end_writes();
		send_item(REQ_INSERT, 32'h1234_5678);
		send_item(REQ_INSERT, 32'd7);
		send_item(REQ_REPORT, 32'd0);
		settle();

		write_reg(CFG_SEED, $urandom | 32'd1);
		write_reg(CFG_ADMIT, 32'd40000);
		write_reg(CFG_MINCNT, 32'd1);
		end_writes();
		random_items(40, 8);
		settle();

		calm <= 1'b1;
		write_reg(CFG_SEED, 32'hFFFF_FFFF);
		write_reg(CFG_ADMIT, $urandom_range(65536));
		write_reg(CFG_MINCNT, 32'd0);
		end_writes();
		random_items(40, 24);
		settle();
		calm <= 1'b0;

		write_reg(CFG_SEED, $urandom);
		write_reg(CFG_ADMIT, 32'd65536);
		write_reg(CFG_MINCNT, $urandom_range(3));
		end_writes();
		random_items(45, 16);
		settle();

		if (sb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
